// ----- rtl/fvis_pkg.sv -----
// ----------------------------------------------------------------------------
// fvis_pkg
// Shared types and constants of the frustum and occlusion visibility block.
// ----------------------------------------------------------------------------
package fvis_pkg;

	localparam int MAX_OBSTACLES = 16;
	localparam int BOX_IDX_W     = $clog2(MAX_OBSTACLES);
	localparam int BOX_CNT_W     = $clog2(MAX_OBSTACLES + 1);
	localparam int NUM_PLANES    = 6;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int ROT_W         = 24;

	// request kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// outcome codes
	localparam logic [1:0] OUTCOME_LOAD     = 2'd0;
	localparam logic [1:0] OUTCOME_VISIBLE  = 2'd1;
	localparam logic [1:0] OUTCOME_CULLED   = 2'd2;
	localparam logic [1:0] OUTCOME_OCCLUDED = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_PLANE_0   = 3'd0;
	localparam logic [2:0] CFG_PLANE_5   = 3'd5;
	localparam logic [2:0] CFG_OBST_CNT  = 3'd6;

	typedef struct packed {
		logic               req_type;
		logic [3:0]         slot;
		logic signed [31:0] p0_x;
		logic signed [31:0] p0_y;
		logic signed [31:0] p0_z;
		logic signed [31:0] p1_x;
		logic signed [31:0] p1_y;
		logic signed [31:0] p1_z;
		logic signed [15:0] rot_x;
		logic signed [15:0] rot_y;
		logic signed [15:0] rot_z;
		logic signed [15:0] rot_w;
	} req_item_t;

	typedef struct packed {
		logic       visible;
		logic [1:0] outcome;
	} rsp_item_t;

	// classified work item: for a query b holds the ray, for a load the box max
	typedef struct packed {
		logic               is_query;
		logic [3:0]         slot;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [32:0] b_x;
		logic signed [32:0] b_y;
		logic signed [32:0] b_z;
		logic signed [15:0] q_x;
		logic signed [15:0] q_y;
		logic signed [15:0] q_z;
		logic signed [15:0] q_w;
	} work_t;

	typedef struct packed {
		logic signed [31:0] min_x;
		logic signed [31:0] min_y;
		logic signed [31:0] min_z;
		logic signed [31:0] max_x;
		logic signed [31:0] max_y;
		logic signed [31:0] max_z;
	} box_t;

	typedef logic [NUM_PLANES-1:0][63:0] planes_t;

endpackage

// ----- rtl/fvis_front.sv -----
// ----------------------------------------------------------------------------
// fvis_front
// Accepts request items, classifies them and forms the ray of a query.
// ----------------------------------------------------------------------------
module fvis_front import fvis_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req_item,
	output logic      push_valid,
	input  logic      push_ready,
	output work_t     push_item
);

	logic  vld_s1;
	work_t item_s1;
	work_t cls;
	logic  query;

	assign query     = (req_item.req_type == REQ_QUERY);
	assign req_ready = !vld_s1 || push_ready;

	always_comb begin
		cls.is_query = query;
		cls.slot     = req_item.slot;
		cls.a_x      = req_item.p0_x;
		cls.a_y      = req_item.p0_y;
		cls.a_z      = req_item.p0_z;
		cls.q_x      = req_item.rot_x;
		cls.q_y      = req_item.rot_y;
		cls.q_z      = req_item.rot_z;
		cls.q_w      = req_item.rot_w;
		if (query) begin
			cls.b_x = 33'(req_item.p1_x) - 33'(req_item.p0_x);
			cls.b_y = 33'(req_item.p1_y) - 33'(req_item.p0_y);
			cls.b_z = 33'(req_item.p1_z) - 33'(req_item.p0_z);
		end else begin
			cls.b_x = 33'(req_item.p1_x);
			cls.b_y = 33'(req_item.p1_y);
			cls.b_z = 33'(req_item.p1_z);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= cls;
		end
	end

	assign push_valid = vld_s1;
	assign push_item  = item_s1;

endmodule

// ----- rtl/fvis_queue.sv -----
// ----------------------------------------------------------------------------
// fvis_queue
// Short queue of classified work items between the front and the back.
// ----------------------------------------------------------------------------
module fvis_queue import fvis_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  work_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output work_t pop_item
);

	work_t             ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = ent_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/fvis_back.sv -----
// ----------------------------------------------------------------------------
// fvis_back
// Executes work items: box loads, plane tests and slab tests on one shared
// multiplier, and holds the result register.
// ----------------------------------------------------------------------------
module fvis_back import fvis_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  work_t      pop_item,
	input  planes_t    planes,
	input  logic [4:0] obst_count,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_item_t  rsp_item
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PRE   = 7'b0000010,
		ST_PLANE = 7'b0000100,
		ST_RDBOX = 7'b0001000,
		ST_AXIS  = 7'b0010000,
		ST_FINAL = 7'b0100000,
		ST_RES   = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [4:0]             step_q;
	logic [2:0]             pl_q;
	logic [BOX_CNT_W-1:0]   bx_q;
	logic [1:0]             k_q;
	logic                   have_q;
	logic [1:0]             res_q;
	logic                   rsp_valid_q;
	rsp_item_t              rsp_q;

	logic signed [31:0]     cam_q [3];
	logic signed [32:0]     ray_q [3];
	logic signed [15:0]     u_q [3];
	logic signed [15:0]     s_q;
	logic signed [33:0]     ss_q;
	logic signed [33:0]     ssmu_q;
	logic signed [33:0]     ud_q;
	logic signed [33:0]     cr_q [3];
	logic signed [63:0]     acc_q;
	logic signed [ROT_W-1:0] rot_q [3];
	logic signed [63:0]     dist_q;
	logic signed [67:0]     tmp_q;
	logic signed [33:0]     lo_n_q;
	logic signed [33:0]     hi_n_q;
	logic [32:0]            lo_d_q;
	logic [32:0]            hi_d_q;

	box_t                   mem [MAX_OBSTACLES];
	box_t                   rd_q;

	logic signed [33:0]     ma;
	logic signed [33:0]     mb;
	logic signed [67:0]     prod_q;
	logic signed [63:0]     p64;

	logic [63:0]            plane;
	logic signed [15:0]     n0;
	logic signed [15:0]     n1;
	logic signed [15:0]     n2;
	logic signed [15:0]     dp;
	logic signed [63:0]     rsum;
	logic signed [ROT_W-1:0] rnd;
	logic signed [63:0]     dist_fin;
	logic [BOX_CNT_W-1:0]   cnt_eff;

	logic signed [31:0]     cam_k;
	logic signed [32:0]     ray_k;
	logic signed [31:0]     bmin_k;
	logic signed [31:0]     bmax_k;
	logic signed [33:0]     d0;
	logic signed [33:0]     d1;
	logic signed [33:0]     m0;
	logic signed [33:0]     m1;
	logic signed [33:0]     sa;
	logic signed [33:0]     sb;
	logic [32:0]            den;
	logic signed [33:0]     den_s;
	logic signed [31:0]     bl;
	logic signed [31:0]     bh;
	logic                   ray_neg;
	logic                   ray_zero;
	logic                   cam_in;
	logic                   last_box;
	logic                   hit_fin;

	assign plane = planes[pl_q];
	assign n0    = plane[15:0];
	assign n1    = plane[31:16];
	assign n2    = plane[47:32];
	assign dp    = plane[63:48];

	assign p64      = prod_q[63:0];
	// round half up from 2^42 scale to 2^14 scale
	assign rsum     = acc_q + (p64 <<< 1) + 64'sd134217728;
	assign rnd      = rsum[ROT_W+27:28];
	assign dist_fin = dist_q + p64 + (64'(dp) <<< 25);

	assign cnt_eff  = (obst_count > 5'(MAX_OBSTACLES)) ? BOX_CNT_W'(MAX_OBSTACLES)
	                                                   : BOX_CNT_W'(obst_count);
	assign last_box = (bx_q + 1'b1 == cnt_eff);

	// interval not empty, not behind the camera, starts before the target
	assign hit_fin  = (tmp_q <= prod_q) && (hi_n_q >= 0)
	                  && (lo_n_q < $signed({1'b0, lo_d_q}));

	// per-axis slab terms
	always_comb begin
		cam_k = cam_q[k_q];
		ray_k = ray_q[k_q];
		case (k_q)
			2'd0: begin
				bmin_k = rd_q.min_x;
				bmax_k = rd_q.max_x;
			end
			2'd1: begin
				bmin_k = rd_q.min_y;
				bmax_k = rd_q.max_y;
			end
			default: begin
				bmin_k = rd_q.min_z;
				bmax_k = rd_q.max_z;
			end
		endcase
		d0       = 34'(bmin_k) - 34'(cam_k);
		d1       = 34'(bmax_k) - 34'(cam_k);
		ray_neg  = (ray_k < 0);
		ray_zero = (ray_k == '0);
		den      = ray_neg ? 33'(-ray_k) : 33'(ray_k);
		den_s    = $signed({1'b0, den});
		m0       = ray_neg ? -d0 : d0;
		m1       = ray_neg ? -d1 : d1;
		sa       = (m0 < m1) ? m0 : m1;
		sb       = (m0 < m1) ? m1 : m0;
		bl       = (bmin_k < bmax_k) ? bmin_k : bmax_k;
		bh       = (bmin_k < bmax_k) ? bmax_k : bmin_k;
		cam_in   = (cam_k >= bl) && (cam_k <= bh);
	end

	// shared multiplier operands
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			ST_PRE: begin
				case (step_q)
					5'd0: begin ma = 34'(s_q);    mb = 34'(s_q);    end
					5'd1: begin ma = 34'(u_q[0]); mb = 34'(u_q[0]); end
					5'd2: begin ma = 34'(u_q[1]); mb = 34'(u_q[1]); end
					5'd3: begin ma = 34'(u_q[2]); mb = 34'(u_q[2]); end
					default: ;
				endcase
			end
			ST_PLANE: begin
				case (step_q)
					5'd0:  begin ma = 34'(u_q[0]);   mb = 34'(n0);       end
					5'd1:  begin ma = 34'(u_q[1]);   mb = 34'(n1);       end
					5'd2:  begin ma = 34'(u_q[2]);   mb = 34'(n2);       end
					5'd3:  begin ma = 34'(u_q[1]);   mb = 34'(n2);       end
					5'd4:  begin ma = 34'(u_q[2]);   mb = 34'(n1);       end
					5'd5:  begin ma = 34'(u_q[2]);   mb = 34'(n0);       end
					5'd6:  begin ma = 34'(u_q[0]);   mb = 34'(n2);       end
					5'd7:  begin ma = 34'(u_q[0]);   mb = 34'(n1);       end
					5'd8:  begin ma = 34'(u_q[1]);   mb = 34'(n0);       end
					5'd9:  begin ma = ud_q;          mb = 34'(u_q[0]);   end
					5'd10: begin ma = ssmu_q;        mb = 34'(n0);       end
					5'd11: begin ma = 34'(s_q);      mb = cr_q[0];       end
					5'd12: begin ma = ud_q;          mb = 34'(u_q[1]);   end
					5'd13: begin ma = ssmu_q;        mb = 34'(n1);       end
					5'd14: begin ma = 34'(s_q);      mb = cr_q[1];       end
					5'd15: begin ma = ud_q;          mb = 34'(u_q[2]);   end
					5'd16: begin ma = ssmu_q;        mb = 34'(n2);       end
					5'd17: begin ma = 34'(s_q);      mb = cr_q[2];       end
					5'd18: begin ma = 34'(ray_q[0]); mb = 34'(rot_q[0]); end
					5'd19: begin ma = 34'(ray_q[1]); mb = 34'(rot_q[1]); end
					5'd20: begin ma = 34'(ray_q[2]); mb = 34'(rot_q[2]); end
					default: ;
				endcase
			end
			ST_AXIS: begin
				case (step_q)
					5'd0: begin ma = sa;     mb = $signed({1'b0, lo_d_q}); end
					5'd1: begin ma = lo_n_q; mb = den_s;                   end
					5'd2: begin ma = sb;     mb = $signed({1'b0, hi_d_q}); end
					5'd3: begin ma = hi_n_q; mb = den_s;                   end
					default: ;
				endcase
			end
			ST_FINAL: begin
				case (step_q)
					5'd0: begin ma = lo_n_q; mb = $signed({1'b0, hi_d_q}); end
					5'd1: begin ma = hi_n_q; mb = $signed({1'b0, lo_d_q}); end
					default: ;
				endcase
			end
			ST_IDLE, ST_RDBOX, ST_RES: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
	end

	// obstacle table
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid && !pop_item.is_query) begin
			mem[pop_item.slot] <= '{min_x: pop_item.a_x, min_y: pop_item.a_y,
			                        min_z: pop_item.a_z, max_x: pop_item.b_x[31:0],
			                        max_y: pop_item.b_y[31:0], max_z: pop_item.b_z[31:0]};
		end
		if (state_q == ST_RDBOX) begin
			rd_q <= mem[bx_q[BOX_IDX_W-1:0]];
		end
	end

	assign pop_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			pl_q        <= '0;
			bx_q        <= '0;
			k_q         <= '0;
			have_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						step_q <= '0;
						pl_q   <= '0;
						state_q <= pop_item.is_query ? ST_PRE : ST_RES;
					end
				end
				ST_PRE: begin
					step_q <= step_q + 1'b1;
					if (step_q == 5'd4) begin
						step_q  <= '0;
						state_q <= ST_PLANE;
					end
				end
				ST_PLANE: begin
					step_q <= step_q + 1'b1;
					if (step_q == 5'd21) begin
						step_q <= '0;
						if (dist_fin < 0) begin
							state_q <= ST_RES;
						end else if (pl_q == 3'(NUM_PLANES - 1)) begin
							bx_q    <= '0;
							state_q <= (cnt_eff == '0) ? ST_RES : ST_RDBOX;
						end else begin
							pl_q <= pl_q + 1'b1;
						end
					end
				end
				ST_RDBOX: begin
					step_q  <= '0;
					k_q     <= '0;
					have_q  <= 1'b0;
					state_q <= ST_AXIS;
				end
				ST_AXIS: begin
					step_q <= step_q + 1'b1;
					if (step_q == 5'd0 && (ray_zero || !have_q)) begin
						step_q <= '0;
						if (ray_zero && !cam_in) begin
							// box missed on this axis
							if (last_box) begin
								state_q <= ST_RES;
							end else begin
								bx_q    <= bx_q + 1'b1;
								state_q <= ST_RDBOX;
							end
						end else begin
							if (!ray_zero) begin
								have_q <= 1'b1;
							end
							k_q <= k_q + 1'b1;
							if (k_q == 2'd2) begin
								state_q <= ST_FINAL;
							end
						end
					end else if (step_q == 5'd4) begin
						step_q <= '0;
						k_q    <= k_q + 1'b1;
						if (k_q == 2'd2) begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_FINAL: begin
					step_q <= step_q + 1'b1;
					if (!have_q || step_q == 5'd2) begin
						step_q <= '0;
						if (!have_q || hit_fin) begin
							state_q <= ST_RES;
						end else if (last_box) begin
							state_q <= ST_RES;
						end else begin
							bx_q    <= bx_q + 1'b1;
							state_q <= ST_RDBOX;
						end
					end
				end
				ST_RES: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cam_q[0] <= pop_item.a_x;
				cam_q[1] <= pop_item.a_y;
				cam_q[2] <= pop_item.a_z;
				ray_q[0] <= pop_item.b_x;
				ray_q[1] <= pop_item.b_y;
				ray_q[2] <= pop_item.b_z;
				u_q[0]   <= pop_item.q_x;
				u_q[1]   <= pop_item.q_y;
				u_q[2]   <= pop_item.q_z;
				s_q      <= pop_item.q_w;
				res_q    <= OUTCOME_LOAD;
			end
			ST_PRE: begin
				case (step_q)
					5'd1: ss_q   <= prod_q[33:0];
					5'd2: ssmu_q <= ss_q - prod_q[33:0];
					5'd3: ssmu_q <= ssmu_q - prod_q[33:0];
					5'd4: ssmu_q <= ssmu_q - prod_q[33:0];
					default: ;
				endcase
			end
			ST_PLANE: begin
				case (step_q)
					5'd1: ud_q    <= prod_q[33:0];
					5'd2: ud_q    <= ud_q + prod_q[33:0];
					5'd3: ud_q    <= ud_q + prod_q[33:0];
					5'd4: cr_q[0] <= prod_q[33:0];
					5'd5: cr_q[0] <= cr_q[0] - prod_q[33:0];
					5'd6: cr_q[1] <= prod_q[33:0];
					5'd7: cr_q[1] <= cr_q[1] - prod_q[33:0];
					5'd8: cr_q[2] <= prod_q[33:0];
					5'd9: cr_q[2] <= cr_q[2] - prod_q[33:0];
					5'd10, 5'd13, 5'd16: acc_q <= p64 <<< 1;
					5'd11, 5'd14, 5'd17: acc_q <= acc_q + p64;
					5'd12: rot_q[0] <= rnd;
					5'd15: rot_q[1] <= rnd;
					5'd18: rot_q[2] <= rnd;
					5'd19: dist_q <= p64;
					5'd20: dist_q <= dist_q + p64;
					5'd21: begin
						if (dist_fin < 0) begin
							res_q <= OUTCOME_CULLED;
						end else if (pl_q == 3'(NUM_PLANES - 1)) begin
							res_q <= OUTCOME_VISIBLE;
						end
					end
					default: ;
				endcase
			end
			ST_AXIS: begin
				case (step_q)
					5'd0: begin
						if (!ray_zero && !have_q) begin
							lo_n_q <= sa;
							lo_d_q <= den;
							hi_n_q <= sb;
							hi_d_q <= den;
						end
					end
					5'd1: tmp_q <= prod_q;
					5'd2: begin
						if (tmp_q > prod_q) begin
							lo_n_q <= sa;
							lo_d_q <= den;
						end
					end
					5'd3: tmp_q <= prod_q;
					5'd4: begin
						if (tmp_q < prod_q) begin
							hi_n_q <= sb;
							hi_d_q <= den;
						end
					end
					default: ;
				endcase
			end
			ST_FINAL: begin
				if (!have_q) begin
					res_q <= OUTCOME_OCCLUDED;
				end else begin
					case (step_q)
						5'd1: tmp_q <= prod_q;
						5'd2: begin
							if (hit_fin) begin
								res_q <= OUTCOME_OCCLUDED;
							end
						end
						default: ;
					endcase
				end
			end
			ST_RES: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_q.outcome <= res_q;
					rsp_q.visible <= (res_q == OUTCOME_VISIBLE);
				end
			end
			ST_RDBOX: ;
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

endmodule

// ----- rtl/frustum_and_occlusion_visibility.sv -----
// ----------------------------------------------------------------------------
// frustum_and_occlusion_visibility
// Frustum culling and ray-versus-box occlusion of query targets against a
// table of obstacle boxes.
// ----------------------------------------------------------------------------
//  channel  signals                        direction  carries
//  req      req_valid/req_ready/req_item   in         box load or query
//  rsp      rsp_valid/rsp_ready/rsp_item   out        visible flag, outcome
//  cfg      cfg_valid/cfg_ready/cfg_index  in         plane and count writes
//           cfg_data
//
// A load passes the front register, the queue and the result register.
// A query adds, on one shared 34x34 multiplier, a setup step, a test per
// frustum plane, then per tested box a table read, a test per axis and a
// closing step; the first hit or cull ends it.
// Reset clears control state and all configuration registers; the box table
// is not cleared. Until they are full, the front and a two-entry queue keep
// taking items while the back works or waits on a stalled rsp channel.
// ----------------------------------------------------------------------------
module frustum_and_occlusion_visibility import fvis_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_item_t   req_item,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_item_t   rsp_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	planes_t    planes_q;
	logic [4:0] obst_count_q;

	logic  push_valid;
	logic  push_ready;
	work_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	work_t pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q     <= '0;
			obst_count_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index >= CFG_PLANE_0 && cfg_index <= CFG_PLANE_5) begin
				planes_q[cfg_index] <= cfg_data;
			end else if (cfg_index == CFG_OBST_CNT) begin
				obst_count_q <= cfg_data[4:0];
			end
		end
	end

	fvis_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_item   (req_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	fvis_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	fvis_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item),
		.planes     (planes_q),
		.obst_count (obst_count_q),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp_item   (rsp_item)
	);

endmodule

// ----- bench/frustum_and_occlusion_visibility_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frustum_and_occlusion_visibility_tb
// Drives box loads and visibility queries through the req channel, programs
// planes and obstacle count between phases, and checks every response against
// an in-bench visibility predictor kept in step with accepted transfers.
// ----------------------------------------------------------------------------
module frustum_and_occlusion_visibility_tb;
	import fvis_pkg::*;

	typedef longint unsigned u64_t;

	localparam int  LIMIT_CYCLES = 4_000_000;
	localparam longint NEAR      = 64'sd4194304;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_item_t   req_item;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_item_t   rsp_item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	frustum_and_occlusion_visibility dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	req_item_t  pending_req_q[$];
	rsp_item_t  expected_rsp_q[$];
	logic [63:0] plane_cfg[NUM_PLANES];
	logic [4:0]  obst_cnt_cfg;
	longint      box_lo[MAX_OBSTACLES][3];
	longint      box_hi[MAX_OBSTACLES][3];
	int          mismatches;
	bit          idle_en;
	logic        hold_start;
	int          hold_left;
	int          send_gap;
	int          recv_gap;
	int          cycles;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// compare a/b with c/d, b and d positive
	function automatic int frac_cmp(longint a, longint b, longint c, longint d);
		int   sa, sc;
		u64_t l, r;
		sa = (a > 0) ? 1 : ((a < 0) ? -1 : 0);
		sc = (c > 0) ? 1 : ((c < 0) ? -1 : 0);
		if (sa != sc)
			return (sa < sc) ? -1 : 1;
		if (sa == 0)
			return 0;
		l = u64_t'(a < 0 ? -a : a) * u64_t'(d);
		r = u64_t'(c < 0 ? -c : c) * u64_t'(b);
		if (l == r)
			return 0;
		if (sa > 0)
			return (l < r) ? -1 : 1;
		return (l < r) ? 1 : -1;
	endfunction

	function automatic bit ray_hits_box(longint cam[3], longint ray[3], int idx);
		bit     have;
		longint lo_n, lo_d, hi_n, hi_d, n0, n1, den, a, b, lb, hb;
		have = 0;
		lo_n = 0; lo_d = 1; hi_n = 0; hi_d = 1;
		for (int k = 0; k < 3; k++) begin
			n0 = box_lo[idx][k] - cam[k];
			n1 = box_hi[idx][k] - cam[k];
			den = ray[k];
			if (den == 0) begin
				lb = (box_lo[idx][k] < box_hi[idx][k]) ? box_lo[idx][k] : box_hi[idx][k];
				hb = (box_lo[idx][k] < box_hi[idx][k]) ? box_hi[idx][k] : box_lo[idx][k];
				if (cam[k] < lb || cam[k] > hb)
					return 0;
				continue;
			end
			if (den < 0) begin
				n0 = -n0; n1 = -n1; den = -den;
			end
			a = (n0 < n1) ? n0 : n1;
			b = (n0 < n1) ? n1 : n0;
			if (!have) begin
				lo_n = a; lo_d = den; hi_n = b; hi_d = den;
				have = 1;
			end else begin
				if (frac_cmp(a, den, lo_n, lo_d) > 0) begin lo_n = a; lo_d = den; end
				if (frac_cmp(b, den, hi_n, hi_d) < 0) begin hi_n = b; hi_d = den; end
			end
		end
		if (!have)
			return 1;
		if (frac_cmp(lo_n, lo_d, hi_n, hi_d) > 0)
			return 0;
		if (hi_n < 0)
			return 0;
		return lo_n < lo_d;
	endfunction

	function automatic rsp_item_t predict_visibility(req_item_t it);
		longint    cam[3], tgt[3], ray[3], u[3], n[3], cr[3], rot[3];
		longint    s, ud, uu, pdist;
		logic [63:0] pr;
		int        cnt;
		rsp_item_t r;
		cam[0] = longint'($signed(it.p0_x));
		cam[1] = longint'($signed(it.p0_y));
		cam[2] = longint'($signed(it.p0_z));
		tgt[0] = longint'($signed(it.p1_x));
		tgt[1] = longint'($signed(it.p1_y));
		tgt[2] = longint'($signed(it.p1_z));
		r.visible = 1'b0;
		if (it.req_type == REQ_LOAD) begin
			for (int k = 0; k < 3; k++) begin
				box_lo[it.slot][k] = cam[k];
				box_hi[it.slot][k] = tgt[k];
			end
			r.outcome = OUTCOME_LOAD;
			return r;
		end
		for (int k = 0; k < 3; k++)
			ray[k] = tgt[k] - cam[k];
		u[0] = longint'($signed(it.rot_x));
		u[1] = longint'($signed(it.rot_y));
		u[2] = longint'($signed(it.rot_z));
		s = longint'($signed(it.rot_w));
		for (int p = 0; p < NUM_PLANES; p++) begin
			pr = plane_cfg[p];
			n[0] = longint'($signed(pr[15:0]));
			n[1] = longint'($signed(pr[31:16]));
			n[2] = longint'($signed(pr[47:32]));
			ud = u[0] * n[0] + u[1] * n[1] + u[2] * n[2];
			uu = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
			cr[0] = u[1] * n[2] - u[2] * n[1];
			cr[1] = u[2] * n[0] - u[0] * n[2];
			cr[2] = u[0] * n[1] - u[1] * n[0];
			// round half up from 2^42 down to 2^14
			for (int j = 0; j < 3; j++)
				rot[j] = (2 * ud * u[j] + (s * s - uu) * n[j] + 2 * s * cr[j]
					+ (longint'(1) <<< 27)) >>> 28;
			pdist = ray[0] * rot[0] + ray[1] * rot[1] + ray[2] * rot[2]
				+ longint'($signed(pr[63:48])) * (longint'(1) <<< 25);
			if (pdist < 0) begin
				r.outcome = OUTCOME_CULLED;
				return r;
			end
		end
		cnt = (obst_cnt_cfg > MAX_OBSTACLES) ? MAX_OBSTACLES : int'(obst_cnt_cfg);
		for (int i = 0; i < cnt; i++)
			if (ray_hits_box(cam, ray, i)) begin
				r.outcome = OUTCOME_OCCLUDED;
				return r;
			end
		r.visible = 1'b1;
		r.outcome = OUTCOME_VISIBLE;
		return r;
	endfunction

	// driver: feed pending items, with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_item  <= '0;
			send_gap  <= 0;
		end else begin
			if (req_valid && req_ready)
				expected_rsp_q.push_back(predict_visibility(req_item));
			if (!req_valid || req_ready) begin
				if (send_gap > 0) begin
					send_gap  <= send_gap - 1;
					req_valid <= 1'b0;
				end else if (idle_en && $urandom_range(0, 19) == 0) begin
					send_gap  <= $urandom_range(0, 16);
					req_valid <= 1'b0;
				end else if (pending_req_q.size() > 0) begin
					req_item  <= pending_req_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_start)
			hold_left <= 5000;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// monitor: stall the rsp channel and check each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			recv_gap  <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response: visible=%0b outcome=%0d",
							rsp_item.visible, rsp_item.outcome);
				end else begin
					rsp_item_t e;
					e = expected_rsp_q.pop_front();
					if (rsp_item.visible !== e.visible || rsp_item.outcome !== e.outcome) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected visible=%0b outcome=%0d, got visible=%0b outcome=%0d",
								e.visible, e.outcome, rsp_item.visible, rsp_item.outcome);
					end
				end
			end
			if (hold_left > 0 || hold_start) begin
				rsp_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap  <= recv_gap - 1;
				rsp_ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 19) == 0) begin
				recv_gap  <= $urandom_range(0, 16);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("[frustum_and_occlusion_visibility] ERROR");
			$finish;
		end
	end

	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_OBST_CNT)
			obst_cnt_cfg = val[4:0];
		else
			plane_cfg[idx] = val;
	endtask

	task automatic wait_drained();
		while (pending_req_q.size() > 0 || req_valid || expected_rsp_q.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [31:0] near_coord();
		return 32'($urandom_range(0, 2 * NEAR) - NEAR);
	endfunction

	function automatic void push_load(int slot, logic [31:0] lx, logic [31:0] ly,
			logic [31:0] lz, logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
		req_item_t it;
		it = req_item_t'({5'($urandom), $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom});
		it.req_type = REQ_LOAD;
		it.slot = slot[3:0];
		it.p0_x = lx; it.p0_y = ly; it.p0_z = lz;
		it.p1_x = hx; it.p1_y = hy; it.p1_z = hz;
		pending_req_q.push_back(it);
	endfunction

	function automatic void push_query(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [31:0] tx, logic [31:0] ty, logic [31:0] tz, logic [63:0] q);
		req_item_t it;
		it = '0;
		it.req_type = REQ_QUERY;
		it.slot = 4'($urandom);
		it.p0_x = cx; it.p0_y = cy; it.p0_z = cz;
		it.p1_x = tx; it.p1_y = ty; it.p1_z = tz;
		{it.rot_x, it.rot_y, it.rot_z, it.rot_w} = q;
		pending_req_q.push_back(it);
	endfunction

	function automatic void push_random_box(int slot);
		logic [31:0] a[3], b[3], t;
		for (int k = 0; k < 3; k++) begin
			a[k] = near_coord();
			b[k] = 32'($signed(a[k]) + $urandom_range(0, 1 << 21));
			if ($urandom_range(0, 7) == 0) begin
				t = a[k]; a[k] = b[k]; b[k] = t;
			end
		end
		push_load(slot, a[0], a[1], a[2], b[0], b[1], b[2]);
	endfunction

	function automatic void push_random_query(bit wide);
		logic [31:0] c[3], t[3];
		for (int k = 0; k < 3; k++) begin
			c[k] = wide ? 32'($urandom) : near_coord();
			t[k] = ($urandom_range(0, 3) == 0) ? c[k] : (wide ? 32'($urandom) : near_coord());
		end
		push_query(c[0], c[1], c[2], t[0], t[1], t[2], {$urandom, $urandom});
	endfunction

	function automatic logic [63:0] random_plane(int mode);
		logic [63:0] p;
		p = {$urandom, $urandom};
		case (mode)
			0: p = '0;
			1: p[63:48] = 16'h7fff;
			2: p[63:48] = 16'($urandom_range(0, 4000));
			default: ;
		endcase
		return p;
	endfunction

	initial begin
		logic [63:0] unit_q;
		int          cnt_pick[6];
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req_item     = '0;
		rsp_ready    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_PLANE_0;
		cfg_data     = '0;
		hold_start   = 1'b0;
		idle_en      = 1'b1;
		mismatches   = 0;
		cycles       = 0;
		obst_cnt_cfg = '0;
		for (int p = 0; p < NUM_PLANES; p++)
			plane_cfg[p] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty frustum, all slots loaded
		unit_q = {16'sd0, 16'sd0, 16'sd0, 16'sd16384};
		for (int p = 0; p < NUM_PLANES; p++)
			cfg_write(CFG_PLANE_0 + 3'(p), '0);
		cfg_write(CFG_OBST_CNT, 64'd16);
		push_load(0, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh20000, 32'sh20000);
		// inverted bounds
		push_load(1, 32'sh60000, 32'sh60000, 32'sh60000, 32'sh50000, 32'sh50000, 32'sh50000);
		for (int i = 2; i < MAX_OBSTACLES; i++)
			push_load(i, 32'sh7f000000, 32'sh7f000000, 32'sh7f000000,
				32'sh7f100000, 32'sh7f100000, 32'sh7f100000);
		// zero ray inside a box, then outside all boxes
		push_query(32'sh18000, 32'sh18000, 32'sh18000, 32'sh18000, 32'sh18000, 32'sh18000, unit_q);
		push_query(32'sh30000, 32'sh30000, 32'sh30000, 32'sh30000, 32'sh30000, 32'sh30000, unit_q);
		// through box 0, through the inverted box, box behind the camera, short of it
		push_query(0, 0, 0, 32'sh40000, 32'sh40000, 32'sh40000, unit_q);
		push_query(32'sh40000, 32'sh40000, 32'sh40000, 32'sh80000, 32'sh80000, 32'sh80000, unit_q);
		push_query(32'sh30000, 32'sh30000, 32'sh30000, 32'sh40000, 32'sh40000, 32'sh40000, unit_q);
		push_query(0, 0, 0, 32'sh8000, 32'sh8000, 32'sh8000, unit_q);
		// zero ray component on one axis, inside and outside the slab
		push_query(0, 32'sh18000, 32'sh18000, 32'sh40000, 32'sh18000, 32'sh18000, unit_q);
		push_query(0, 32'sh30000, 32'sh18000, 32'sh40000, 32'sh30000, 32'sh18000, unit_q);
		wait_drained();

		// directed: field extremes and a culling plane, no boxes tested
		cfg_write(CFG_OBST_CNT, 64'd0);
		cfg_write(CFG_PLANE_0, {16'h8000, 16'h0000, 16'h0000, 16'h4000});
		push_query(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
		push_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h80000000, {16'h8000, 16'h8000, 16'h8000, 16'h8000});
		push_query(0, 0, 0, 32'h7fffffff, 0, 0, unit_q);
		push_query(0, 0, 0, 32'h80000000, 0, 0, unit_q);
		push_load(5, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		wait_drained();
		cfg_write(CFG_PLANE_0, {64{1'b1}});
		cfg_write(CFG_OBST_CNT, 64'd31);
		for (int i = 0; i < MAX_OBSTACLES; i++)
			push_random_box(i);
		for (int i = 0; i < 4; i++)
			push_random_query(0);
		wait_drained();

		// random phases with varied frustum and obstacle count
		cnt_pick = '{16, 31, 1, 8, 17, 5};
		for (int ph = 0; ph < 6; ph++) begin
			for (int p = 0; p < NUM_PLANES; p++)
				cfg_write(CFG_PLANE_0 + 3'(p), random_plane((ph + p) % 4));
			cfg_write(CFG_OBST_CNT, 64'(cnt_pick[ph]));
			if (ph == 5)
				idle_en = 1'b0;
			for (int i = 0; i < MAX_OBSTACLES; i++)
				push_random_box(i);
			for (int i = 0; i < 190; i++)
				if ($urandom_range(0, 4) == 0)
					push_random_box($urandom_range(0, MAX_OBSTACLES - 1));
				else
					push_random_query(cnt_pick[ph] == 1 && $urandom_range(0, 1) == 0);
			if (ph == 1) begin
				@(posedge clk);
				hold_start <= 1'b1;
				@(posedge clk);
				hold_start <= 1'b0;
			end
			wait_drained();
		end

		// wide-range queries with no boxes tested
		cfg_write(CFG_OBST_CNT, 64'd0);
		for (int i = 0; i < 40; i++)
			push_random_query(1);
		wait_drained();

		if (mismatches == 0 && expected_rsp_q.size() == 0)
			$display("[frustum_and_occlusion_visibility] OK");
		else
			$display("[frustum_and_occlusion_visibility] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/fvis_pkg.sv
rtl/fvis_front.sv
rtl/fvis_queue.sv
rtl/fvis_back.sv
rtl/frustum_and_occlusion_visibility.sv
bench/frustum_and_occlusion_visibility_tb.sv
